### rtl/interval_slot_edf_assigner_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the interval slot assigner
// Shared property shapes used by the blocks that carry assertions.
// ----------------------------------------------------------------------------
`ifndef INTERVAL_SLOT_EDF_ASSIGNER_TOP_DEFINES_SVH
`define INTERVAL_SLOT_EDF_ASSIGNER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define ISEA_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("isea assertion failed");

// Next-cycle implication, disabled while reset is high.
`define ISEA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("isea assertion failed");

`endif

### rtl/isea_pkg.sv
// ----------------------------------------------------------------------------
// isea_pkg
// Shared constants and controller/datapath signal groups of the assigner.
// ----------------------------------------------------------------------------
package isea_pkg;

  // Default set capacity.
  localparam int MAX_N_DEF = 32;

  // Fixed field widths.
  localparam int END_W  = 6;
  localparam int IDX_W  = 5;
  localparam int POS_W  = 7;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic wr_en;
    logic clr_taken;
    logic search_clr;
    logic rd_en;
    logic axis;
    logic commit;
    logic emit_rd;
    logic out_load;
    logic out_fail;
    logic emit_last;
  } isea_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic ok;
    logic out_free;
  } isea_status_t;

endpackage

### rtl/isea_in_if.sv
// ----------------------------------------------------------------------------
// isea_in_if
// Input channel: one item carries a column and a row interval.
// ----------------------------------------------------------------------------
interface isea_in_if import isea_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [END_W-1:0] col_low;
  logic [END_W-1:0] col_high;
  logic [END_W-1:0] row_low;
  logic [END_W-1:0] row_high;
  logic             final_item;

  modport source (output valid, col_low, col_high, row_low, row_high, final_item,
                  input ready);
  modport sink (input valid, col_low, col_high, row_low, row_high, final_item,
                output ready);
endinterface

### rtl/isea_out_if.sv
// ----------------------------------------------------------------------------
// isea_out_if
// Output channel: one placement per item, or one impossible result.
// ----------------------------------------------------------------------------
interface isea_out_if import isea_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] item_index;
  logic [END_W-1:0] placed_col;
  logic [END_W-1:0] placed_row;
  logic             impossible;
  logic             final_result;

  modport source (output valid, item_index, placed_col, placed_row, impossible,
                  final_result, input ready);
  modport sink (input valid, item_index, placed_col, placed_row, impossible,
                final_result, output ready);
endinterface

### rtl/isea_datapath.sv
// ----------------------------------------------------------------------------
// isea_datapath
// Interval memories, taken marks, best-candidate search, placement store
// and the output register.
// ----------------------------------------------------------------------------
module isea_datapath import isea_pkg::*; #(
  parameter int MAX_N = MAX_N_DEF,
  parameter int AW    = (MAX_N > 1) ? $clog2(MAX_N) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  isea_cmd_t        cmd,
  output isea_status_t     status,
  input  logic [AW-1:0]    wr_addr,
  input  logic [AW-1:0]    rd_addr,
  input  logic [POS_W-1:0] pos,
  input  logic [IDX_W-1:0] emit_index,
  input  logic [END_W-1:0] col_low,
  input  logic [END_W-1:0] col_high,
  input  logic [END_W-1:0] row_low,
  input  logic [END_W-1:0] row_high,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [IDX_W-1:0] item_index,
  output logic [END_W-1:0] placed_col,
  output logic [END_W-1:0] placed_row,
  output logic             impossible,
  output logic             final_result
);

  logic [2*END_W-1:0] col_mem  [MAX_N];
  logic [2*END_W-1:0] row_mem  [MAX_N];
  logic [END_W-1:0]   pcol_mem [MAX_N];
  logic [END_W-1:0]   prow_mem [MAX_N];

  logic [END_W-1:0] lo_q;
  logic [END_W-1:0] hi_q;
  logic [AW-1:0]    k_q;
  logic             v_q;
  logic [MAX_N-1:0] taken;

  logic             found;
  logic             fail;
  logic [AW-1:0]    best_idx;
  logic [END_W-1:0] best_lo;
  logic [END_W-1:0] best_hi;

  logic [END_W-1:0] ecol_q;
  logic [END_W-1:0] erow_q;

  logic cand;
  logic late;
  logic fits;
  logic better;

  // Interval memories: written while loading, read one entry per cycle in a scan.
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      col_mem[wr_addr] <= {col_low, col_high};
      row_mem[wr_addr] <= {row_low, row_high};
    end
    if (cmd.rd_en) begin
      if (cmd.axis) begin
        {lo_q, hi_q} <= row_mem[rd_addr];
      end else begin
        {lo_q, hi_q} <= col_mem[rd_addr];
      end
      k_q <= rd_addr;
    end
  end

  // The read data is valid in the cycle after the read was issued.
  always_ff @(posedge clk) begin
    if (rst) begin
      v_q <= 1'b0;
    end else begin
      v_q <= cmd.rd_en;
    end
  end

  // Judge the entry just read against the current position.
  always_comb begin
    cand   = v_q && !taken[k_q];
    late   = cand && ({1'b0, hi_q} < pos);
    fits   = cand && ({1'b0, lo_q} <= pos);
    better = fits && (!found || (hi_q < best_hi) ||
                      ((hi_q == best_hi) && (lo_q < best_lo)));
  end

  // Running best candidate; the earlier index keeps a full tie.
  always_ff @(posedge clk) begin
    if (rst || cmd.search_clr) begin
      found <= 1'b0;
      fail  <= 1'b0;
    end else begin
      if (late) begin
        fail <= 1'b1;
      end
      if (better) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (better) begin
      best_idx <= k_q;
      best_lo  <= lo_q;
      best_hi  <= hi_q;
    end
  end

  // Taken marks, cleared at the start of each axis.
  always_ff @(posedge clk) begin
    if (rst || cmd.clr_taken) begin
      taken <= '0;
    end else if (cmd.commit) begin
      taken[best_idx] <= 1'b1;
    end
  end

  // Placement store: the winner of each position records it.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (cmd.axis) begin
        prow_mem[best_idx] <= pos[END_W-1:0];
      end else begin
        pcol_mem[best_idx] <= pos[END_W-1:0];
      end
    end
    if (cmd.emit_rd) begin
      ecol_q <= pcol_mem[rd_addr];
      erow_q <= prow_mem[rd_addr];
    end
  end

  // Output register; it holds a result until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load || cmd.out_fail) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_fail) begin
      item_index   <= '0;
      placed_col   <= '0;
      placed_row   <= '0;
      impossible   <= 1'b1;
      final_result <= 1'b1;
    end else if (cmd.out_load) begin
      item_index   <= emit_index;
      placed_col   <= ecol_q;
      placed_row   <= erow_q;
      impossible   <= 1'b0;
      final_result <= cmd.emit_last;
    end
  end

  assign status.ok       = found && !fail;
  assign status.out_free = !out_valid || out_ready;

endmodule

### rtl/isea_ctrl.sv
// ----------------------------------------------------------------------------
// isea_ctrl
// Sequencer: loads a set, walks positions and entries per axis, then emits.
// ----------------------------------------------------------------------------
`include "interval_slot_edf_assigner_top_defines.svh"

module isea_ctrl import isea_pkg::*; #(
  parameter int MAX_N = MAX_N_DEF,
  parameter int AW    = (MAX_N > 1) ? $clog2(MAX_N) : 1,
  parameter int CW    = $clog2(MAX_N + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             final_item,
  output isea_cmd_t        cmd,
  input  isea_status_t     status,
  output logic [AW-1:0]    wr_addr,
  output logic [AW-1:0]    rd_addr,
  output logic [POS_W-1:0] pos,
  output logic [IDX_W-1:0] emit_index
);

  typedef enum logic [2:0] {
    LOAD,
    START,
    SCAN,
    DRAIN,
    COMMIT,
    FAIL_OUT,
    EMIT_RD,
    EMIT_LD
  } state_t;

  state_t        state;
  logic [CW-1:0] count;
  logic [CW-1:0] n;
  logic [CW-1:0] k;
  logic [CW-1:0] p;
  logic [CW-1:0] e;
  logic          axis;

  logic          accept;
  logic          room;

  assign accept = in_valid && in_ready;
  assign room   = count < CW'(MAX_N);

  // Sequencer state and counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= LOAD;
      count <= '0;
      n     <= '0;
      k     <= '0;
      p     <= '0;
      e     <= '0;
      axis  <= 1'b0;
    end else begin
      case (state)
        LOAD: begin
          if (accept) begin
            if (final_item) begin
              n     <= room ? count + CW'(1) : count;
              count <= '0;
              axis  <= 1'b0;
              state <= START;
            end else if (room) begin
              count <= count + CW'(1);
            end
          end
        end
        START: begin
          k <= '0;
          p <= CW'(1);
          if (n == '0) begin
            state <= FAIL_OUT;
          end else begin
            state <= SCAN;
          end
        end
        SCAN: begin
          k <= k + CW'(1);
          if (k == n - CW'(1)) begin
            state <= DRAIN;
          end
        end
        DRAIN: begin
          state <= COMMIT;
        end
        COMMIT: begin
          if (!status.ok) begin
            state <= FAIL_OUT;
          end else if (p == n) begin
            if (!axis) begin
              axis  <= 1'b1;
              state <= START;
            end else begin
              e     <= '0;
              state <= EMIT_RD;
            end
          end else begin
            p     <= p + CW'(1);
            k     <= '0;
            state <= SCAN;
          end
        end
        FAIL_OUT: begin
          if (status.out_free) begin
            state <= LOAD;
          end
        end
        EMIT_RD: begin
          state <= EMIT_LD;
        end
        EMIT_LD: begin
          if (status.out_free) begin
            if (e == n - CW'(1)) begin
              state <= LOAD;
            end else begin
              e     <= e + CW'(1);
              state <= EMIT_RD;
            end
          end
        end
        default: begin
          state <= LOAD;
        end
      endcase
    end
  end

  // Commands decoded from the state.
  always_comb begin
    cmd            = '0;
    cmd.axis       = axis;
    cmd.emit_last  = (e == n - CW'(1));
    cmd.wr_en      = (state == LOAD) && accept && room;
    cmd.clr_taken  = (state == START);
    cmd.search_clr = (state == START) || (state == COMMIT);
    cmd.rd_en      = (state == SCAN);
    cmd.commit     = (state == COMMIT) && status.ok;
    cmd.emit_rd    = (state == EMIT_RD);
    cmd.out_load   = (state == EMIT_LD) && status.out_free;
    cmd.out_fail   = (state == FAIL_OUT) && status.out_free;
  end

  assign in_ready   = (state == LOAD);
  assign wr_addr    = count[AW-1:0];
  assign rd_addr    = (state == SCAN) ? k[AW-1:0] : e[AW-1:0];
  assign pos        = POS_W'(p);
  assign emit_index = IDX_W'(e);

  // A position is only taken by a candidate that fits.
  `ISEA_ASSERT_SAME(a_commit_ok, clk, rst, cmd.commit, status.ok)
  // The output register is loaded only when it is free.
  `ISEA_ASSERT_SAME(a_load_free, clk, rst, cmd.out_load || cmd.out_fail, status.out_free)
  // Scan addresses stay inside the loaded set.
  `ISEA_ASSERT_SAME(a_scan_range, clk, rst, state == SCAN, (k < n) && (p != '0) && (p <= n))
  // After the last placement the block is ready for a new set.
  `ISEA_ASSERT_NEXT(a_emit_done, clk, rst, cmd.out_load && cmd.emit_last, in_ready)

endmodule

### rtl/interval_slot_edf_assigner_top.sv
// ----------------------------------------------------------------------------
// interval_slot_edf_assigner_top
// Earliest-deadline matching of column and row intervals to positions.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one item per handshake: a column interval, a row interval
//   and final_item. Items are taken one per cycle while a set is loading; at
//   most MAX_N are stored and any further item is dropped, though its
//   final_item flag still ends the set.
//   After the last item the block places positions 1..n on the column axis,
//   then on the row axis. Each position scans all n entries, one entry read
//   from the interval memory per cycle, then passes a drain state and a
//   commit state. in_ch is not ready during compute and emit.
//   out_ch then gives one item per loaded item, in load order, each through
//   a placement store read, then the output register; the last one
//   carries final_result. If no full assignment exists, a single item with
//   impossible and final_result set is given instead.
//   The output register holds its item while the sink stalls; loading of the
//   next set starts as soon as the last result is in the register.
//   Reset clears the sequencer, the item count and the output valid.
// ----------------------------------------------------------------------------
module interval_slot_edf_assigner_top import isea_pkg::*; #(
  parameter int MAX_N = MAX_N_DEF
) (
  input  logic   clk,
  input  logic   rst,
  isea_in_if.sink    in_ch,
  isea_out_if.source out_ch
);

  localparam int AW = (MAX_N > 1) ? $clog2(MAX_N) : 1;
  localparam int CW = $clog2(MAX_N + 1);

  isea_cmd_t        cmd;
  isea_status_t     status;
  logic [AW-1:0]    wr_addr;
  logic [AW-1:0]    rd_addr;
  logic [POS_W-1:0] pos;
  logic [IDX_W-1:0] emit_index;

  // Sequencer.
  isea_ctrl #(
    .MAX_N (MAX_N),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .final_item (in_ch.final_item),
    .cmd        (cmd),
    .status     (status),
    .wr_addr    (wr_addr),
    .rd_addr    (rd_addr),
    .pos        (pos),
    .emit_index (emit_index)
  );

  // Storage, search and output register.
  isea_datapath #(
    .MAX_N (MAX_N),
    .AW    (AW)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .wr_addr      (wr_addr),
    .rd_addr      (rd_addr),
    .pos          (pos),
    .emit_index   (emit_index),
    .col_low      (in_ch.col_low),
    .col_high     (in_ch.col_high),
    .row_low      (in_ch.row_low),
    .row_high     (in_ch.row_high),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .item_index   (out_ch.item_index),
    .placed_col   (out_ch.placed_col),
    .placed_row   (out_ch.placed_row),
    .impossible   (out_ch.impossible),
    .final_result (out_ch.final_result)
  );

endmodule

### verif/tb_interval_slot_edf_assigner_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for interval_slot_edf_assigner_top
// Feeds sets of column and row intervals and predicts the earliest-deadline
// placement of positions 1..n on each axis. Every result is checked field by
// field, with random idling on both channels in all but the last test.
// ----------------------------------------------------------------------------
module tb_interval_slot_edf_assigner_top import isea_pkg::*; ();

  localparam int MAX_N          = MAX_N_DEF;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_ITEMS   = 50;
  localparam int DRAIN_CYCLES   = 100;

  // One expected result of the block.
  typedef struct packed {
    logic [IDX_W-1:0] item_index;
    logic [END_W-1:0] placed_col;
    logic [END_W-1:0] placed_row;
    logic             impossible;
    logic             final_result;
  } placement_t;

  // Shape of a generated set.
  typedef enum int {
    SET_CLEAN,
    SET_BROKEN,
    SET_NOISE
  } set_kind_t;

  logic clk = 1'b0;
  logic rst;

  isea_in_if  in_ch ();
  isea_out_if out_ch ();

  interval_slot_edf_assigner_top u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: the intervals of the set being loaded.
  logic [END_W-1:0] col_lo_q [MAX_N];
  logic [END_W-1:0] col_hi_q [MAX_N];
  logic [END_W-1:0] row_lo_q [MAX_N];
  logic [END_W-1:0] row_hi_q [MAX_N];
  int               slot_col [MAX_N];
  int               slot_row [MAX_N];
  int               load_count;

  placement_t placements_due[$];

  bit idle_en;
  int fail_count;
  int items_sent;
  int sets_sent;
  int placements_seen;
  int impossible_seen;
  int idle_cycles;
  int stall_left;

  // Earliest-deadline placement on one axis; returns 0 when no full
  // assignment exists.
  function automatic bit edf_place(input bit row_axis, input int n);
    bit               taken [MAX_N];
    logic [END_W-1:0] lo;
    logic [END_W-1:0] hi;
    logic [END_W-1:0] best_lo;
    logic [END_W-1:0] best_hi;
    int               best;
    bit               found;
    for (int k = 0; k < MAX_N; k++) taken[k] = 1'b0;
    best_lo = '0;
    best_hi = '0;
    for (int p = 1; p <= n; p++) begin
      found = 1'b0;
      best  = 0;
      for (int k = 0; k < n; k++) begin
        if (!taken[k]) begin
          lo = row_axis ? row_lo_q[k] : col_lo_q[k];
          hi = row_axis ? row_hi_q[k] : col_hi_q[k];
          // An open interval that already ended can never be served.
          if (int'(hi) < p) return 1'b0;
          if (int'(lo) <= p) begin
            if (!found || hi < best_hi || (hi == best_hi && lo < best_lo)) begin
              best    = k;
              best_lo = lo;
              best_hi = hi;
              found   = 1'b1;
            end
          end
        end
      end
      if (!found) return 1'b0;
      taken[best] = 1'b1;
      if (row_axis) slot_row[best] = p;
      else slot_col[best] = p;
    end
    return 1'b1;
  endfunction

  // Update the predictor with one accepted item.
  function automatic void take_item(input logic [END_W-1:0] cl, input logic [END_W-1:0] ch,
                                    input logic [END_W-1:0] rl, input logic [END_W-1:0] rh,
                                    input logic fin);
    placement_t exp_p;
    int         n;
    bit         ok;
    // Items beyond the capacity are dropped, but their last flag still counts.
    if (load_count < MAX_N) begin
      col_lo_q[load_count] = cl;
      col_hi_q[load_count] = ch;
      row_lo_q[load_count] = rl;
      row_hi_q[load_count] = rh;
      load_count++;
    end
    if (!fin) return;
    n          = load_count;
    load_count = 0;
    ok = edf_place(1'b0, n);
    if (ok) ok = edf_place(1'b1, n);
    if (!ok || n == 0) begin
      exp_p = '{item_index: '0, placed_col: '0, placed_row: '0,
                impossible: 1'b1, final_result: 1'b1};
      placements_due.push_back(exp_p);
    end else begin
      for (int k = 0; k < n; k++) begin
        exp_p.item_index   = k[IDX_W-1:0];
        exp_p.placed_col   = slot_col[k][END_W-1:0];
        exp_p.placed_row   = slot_row[k][END_W-1:0];
        exp_p.impossible   = 1'b0;
        exp_p.final_result = (k == n - 1);
        placements_due.push_back(exp_p);
      end
    end
  endfunction

  // Send one item; valid stays high afterward unless a gap follows.
  task automatic send_item(input logic [END_W-1:0] cl, input logic [END_W-1:0] ch,
                           input logic [END_W-1:0] rl, input logic [END_W-1:0] rh,
                           input logic fin);
    int gap;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.col_low    <= cl;
    in_ch.col_high   <= ch;
    in_ch.row_low    <= rl;
    in_ch.row_high   <= rh;
    in_ch.final_item <= fin;
    do @(posedge clk); while (!in_ch.ready);
    take_item(cl, ch, rl, rh, fin);
    items_sent++;
  endtask

  // Stop sending and wait until every expected result has come back.
  task automatic hold_sender();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (placements_due.size() != 0);
  endtask

  // Ends of an interval around a chosen position.
  function automatic logic [END_W-1:0] low_end(input int p, input int spread);
    int v;
    v = p - int'($urandom_range(0, spread));
    if (v < 0) v = 0;
    return v[END_W-1:0];
  endfunction

  function automatic logic [END_W-1:0] high_end(input int p, input int spread);
    int v;
    v = p + int'($urandom_range(0, spread));
    return v[END_W-1:0];
  endfunction

  // Send a set of n items. Clean sets hide a valid assignment on both axes;
  // a broken set reverses one interval; noise is random ends. With overflow
  // one more item is sent and dropped, and it carries the last flag.
  task automatic send_set(input int n, input set_kind_t kind, input bit overflow);
    int               col_perm [MAX_N];
    int               row_perm [MAX_N];
    int               j;
    int               t;
    int               spread;
    int               bad_k;
    logic [END_W-1:0] cl;
    logic [END_W-1:0] ch;
    logic [END_W-1:0] rl;
    logic [END_W-1:0] rh;
    for (int k = 0; k < MAX_N; k++) begin
      col_perm[k] = k + 1;
      row_perm[k] = k + 1;
    end
    for (int k = n - 1; k > 0; k--) begin
      j = $urandom_range(0, k);
      t = col_perm[k]; col_perm[k] = col_perm[j]; col_perm[j] = t;
      j = $urandom_range(0, k);
      t = row_perm[k]; row_perm[k] = row_perm[j]; row_perm[j] = t;
    end
    spread = $urandom_range(0, 3);
    bad_k  = $urandom_range(0, n - 1);
    for (int k = 0; k < n; k++) begin
      if (kind == SET_NOISE) begin
        cl = END_W'($urandom);
        ch = END_W'($urandom);
        rl = END_W'($urandom);
        rh = END_W'($urandom);
      end else begin
        cl = low_end(col_perm[k], spread);
        ch = high_end(col_perm[k], spread);
        rl = low_end(row_perm[k], spread);
        rh = high_end(row_perm[k], spread);
        if (kind == SET_BROKEN && k == bad_k) begin
          if ($urandom_range(0, 1) == 0) begin
            cl = ch + 1'b1;
          end else begin
            rl = rh + 1'b1;
          end
        end
      end
      send_item(cl, ch, rl, rh, !overflow && k == n - 1);
    end
    if (overflow) begin
      send_item(END_W'($urandom), END_W'($urandom), END_W'($urandom), END_W'($urandom),
                1'b1);
    end
    sets_sent++;
  endtask

  // Hand-picked sets: extremes, reversed intervals, ties and failures.
  task automatic test_directed();
    // Smallest set.
    send_item(6'd1, 6'd1, 6'd1, 6'd1, 1'b1);
    // Widest ends the fields allow.
    send_item(6'd0, 6'd63, 6'd0, 6'd63, 1'b1);
    // Reversed column interval.
    send_item(6'd5, 6'd2, 6'd1, 6'd1, 1'b1);
    // Second interval ends before its position.
    send_item(6'd1, 6'd1, 6'd1, 6'd2, 1'b0);
    send_item(6'd1, 6'd1, 6'd1, 6'd2, 1'b1);
    // Equal right ends: the smaller left end wins, then the lower index.
    send_item(6'd2, 6'd3, 6'd1, 6'd3, 1'b0);
    send_item(6'd1, 6'd3, 6'd1, 6'd3, 1'b0);
    send_item(6'd1, 6'd3, 6'd1, 6'd3, 1'b1);
    // Columns fit but no row interval covers position one.
    send_item(6'd1, 6'd2, 6'd2, 6'd2, 1'b0);
    send_item(6'd1, 6'd2, 6'd2, 6'd2, 1'b1);
    // A mixed set that fits, with wide right ends.
    send_item(6'd3, 6'd4, 6'd1, 6'd63, 1'b0);
    send_item(6'd1, 6'd63, 6'd4, 6'd4, 1'b0);
    send_item(6'd1, 6'd2, 6'd2, 6'd3, 1'b0);
    send_item(6'd2, 6'd3, 6'd1, 6'd1, 1'b1);
    sets_sent += 7;
    hold_sender();
  endtask

  // A full set plus one dropped item, and a full set that ends normally.
  task automatic test_overflow();
    send_set(MAX_N, SET_CLEAN, 1'b1);
    hold_sender();
    send_set(MAX_N, SET_CLEAN, 1'b0);
  endtask

  // Random sets, mostly small and well formed.
  task automatic test_random();
    int        start;
    int        n;
    int        pick;
    set_kind_t kind;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      n    = ($urandom_range(0, 9) == 0) ? $urandom_range(9, MAX_N) : $urandom_range(1, 8);
      pick = $urandom_range(0, 19);
      kind = (pick < 14) ? SET_CLEAN : (pick < 17) ? SET_BROKEN : SET_NOISE;
      send_set(n, kind, 1'b0);
      if ($urandom_range(0, 4) == 0) hold_sender();
    end
  endtask

  // Back-to-back sets with no idling: the sender never gaps and the sink stays ready.
  task automatic test_no_idle();
    hold_sender();
    idle_en = 1'b0;
    repeat (5) send_set($urandom_range(1, 8), SET_CLEAN, 1'b0);
  endtask

  // Sink side: ready with random stall bursts.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      stall_left   <= 0;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (idle_en && $urandom_range(0, 3) == 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= $urandom_range(0, 4);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Result checker and watchdog.
  always @(posedge clk) begin
    placement_t exp_p;
    if (!rst) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (placements_due.size() == 0) begin
          $error("result with no expectation waiting: item_index %0d", out_ch.item_index);
          fail_count++;
        end else begin
          exp_p = placements_due.pop_front();
          if (out_ch.impossible) impossible_seen++;
          else placements_seen++;
          if (out_ch.item_index !== exp_p.item_index) begin
            $error("item_index: expected %0d, got %0d", exp_p.item_index, out_ch.item_index);
            fail_count++;
          end
          if (out_ch.placed_col !== exp_p.placed_col) begin
            $error("placed_col: expected %0d, got %0d", exp_p.placed_col, out_ch.placed_col);
            fail_count++;
          end
          if (out_ch.placed_row !== exp_p.placed_row) begin
            $error("placed_row: expected %0d, got %0d", exp_p.placed_row, out_ch.placed_row);
            fail_count++;
          end
          if (out_ch.impossible !== exp_p.impossible) begin
            $error("impossible: expected %0d, got %0d", exp_p.impossible, out_ch.impossible);
            fail_count++;
          end
          if (out_ch.final_result !== exp_p.final_result) begin
            $error("final_result: expected %0d, got %0d", exp_p.final_result,
                   out_ch.final_result);
            fail_count++;
          end
        end
      end
    end
  end

  initial begin
    fail_count       = 0;
    items_sent       = 0;
    sets_sent        = 0;
    placements_seen  = 0;
    impossible_seen  = 0;
    idle_cycles      = 0;
    load_count       = 0;
    idle_en          = 1'b1;
    rst              <= 1'b1;
    in_ch.valid      <= 1'b0;
    in_ch.col_low    <= '0;
    in_ch.col_high   <= '0;
    in_ch.row_low    <= '0;
    in_ch.row_high   <= '0;
    in_ch.final_item <= 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_overflow();
    test_random();
    test_no_idle();

    // Let everything drain, then watch for stray results.
    hold_sender();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (placements_due.size() != 0) begin
      $error("%0d expected results never arrived", placements_due.size());
      fail_count++;
    end

    $display("Sent %0d items in %0d sets, including a dropped overflow item.",
             items_sent, sets_sent);
    $display("Checked %0d placements and %0d impossible results.",
             placements_seen, impossible_seen);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
